// File: design/recent_id_move_to_front_counter_macros.svh
// ---------------------------------------------------------------------------
// Recent ID move-to-front counter: assertion macros
// Shared property wrappers for the checker, clocked on clk, held off in reset.
// ---------------------------------------------------------------------------
`ifndef RECENT_ID_MOVE_TO_FRONT_COUNTER_MACROS_SVH
`define RECENT_ID_MOVE_TO_FRONT_COUNTER_MACROS_SVH

// same-cycle implication
`define RIMTF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rimtf assertion failed");

// next-cycle implication
`define RIMTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rimtf assertion failed");

`endif

// File: design/rimtf_pkg.sv
// ---------------------------------------------------------------------------
// Recent ID move-to-front counter: package
// Widths, codes and the structs passed along the cell row.
// ---------------------------------------------------------------------------
package rimtf_pkg;

  localparam int LIST_DEPTH = 8;
  localparam int ID_W       = 32;
  localparam int KIND_W     = 2;
  localparam int OUTC_W     = 2;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_TRADE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WIN     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOSS    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

  localparam logic [OUTC_W-1:0] OUTC_IGNORED = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_KNOWN   = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_NEW     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STATS_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd999;

  typedef struct packed {
    logic            en;
    logic            battle;
    logic [ID_W-1:0] id;
  } cell_ctl_t;

  typedef struct packed {
    logic [ID_W-1:0] trade;
    logic [ID_W-1:0] battle;
    logic            found;
  } link_t;

endpackage

// File: design/rimtf_in_if.sv
// ---------------------------------------------------------------------------
// Recent ID move-to-front counter: input channel
// Valid/ready channel carrying one event item.
// ---------------------------------------------------------------------------
interface rimtf_in_if;
  logic                           valid;
  logic                           ready;
  logic [rimtf_pkg::KIND_W-1:0]   event_kind;
  logic [rimtf_pkg::ID_W-1:0]     partner_id;

  modport source (output valid, output event_kind, output partner_id, input ready);
  modport sink (input valid, input event_kind, input partner_id, output ready);
endinterface

// File: design/rimtf_out_if.sv
// ---------------------------------------------------------------------------
// Recent ID move-to-front counter: result channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface rimtf_out_if;
  logic                           valid;
  logic                           ready;
  logic [rimtf_pkg::OUTC_W-1:0]   outcome;
  logic [rimtf_pkg::CNT_W-1:0]    counter_value;

  modport source (output valid, output outcome, output counter_value, input ready);
  modport sink (input valid, input outcome, input counter_value, output ready);
endinterface

// File: design/rimtf_cell.sv
// ---------------------------------------------------------------------------
// Recent ID move-to-front counter: list cell
// Holds one slot of each list; compares, forwards its slot, loads from left.
// ---------------------------------------------------------------------------
module rimtf_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rimtf_pkg::cell_ctl_t ctl_i,
  input  rimtf_pkg::link_t     link_i,
  output rimtf_pkg::link_t     link_o
);
  import rimtf_pkg::*;

  logic [ID_W-1:0] trade_r, trade_nxt;
  logic [ID_W-1:0] battle_r, battle_nxt;
  logic            match;

  assign match = ctl_i.battle ? (battle_r == ctl_i.id) : (trade_r == ctl_i.id);

  assign link_o.trade  = trade_r;
  assign link_o.battle = battle_r;
  assign link_o.found  = link_i.found | match;

  always_comb begin
    trade_nxt  = trade_r;
    battle_nxt = battle_r;
    if (ctl_i.en && !link_i.found) begin
      if (ctl_i.battle) begin
        battle_nxt = link_i.battle;
      end else begin
        trade_nxt = link_i.trade;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trade_r  <= '0;
      battle_r <= '0;
    end else begin
      trade_r  <= trade_nxt;
      battle_r <= battle_nxt;
    end
  end

endmodule

// File: design/recent_id_move_to_front_counter.sv
// ---------------------------------------------------------------------------
// Recent ID move-to-front counter: top level
// Two move-to-front ID lists in a row of cells, plus three event counters.
// ---------------------------------------------------------------------------
// One event item is taken per clock. The partner ID is compared in every cell
// of a LIST_DEPTH-long row at once; the hit flag ripples down the row and
// decides which cells take their left neighbor's slot, so the list update,
// the counter bump and the result all land at the accept edge and the result
// is shown in the output register from the next cycle. The input stalls only
// while a held result is not taken. Configuration writes are registered.
module recent_id_move_to_front_counter (
  input  logic                            clk,
  input  logic                            rst_n,
  rimtf_in_if.sink                        in_if,
  rimtf_out_if.source                     out_if,
  input  logic                            cfg_we,
  input  logic [rimtf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rimtf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rimtf_pkg::*;

  logic             stats_en_r, link_mode_r;
  logic [CNT_W-1:0] limit_r;
  logic [CNT_W-1:0] trade_cnt_r, trade_cnt_nxt;
  logic [CNT_W-1:0] win_cnt_r, win_cnt_nxt;
  logic [CNT_W-1:0] loss_cnt_r, loss_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUTC_W-1:0] outcome_r, outcome_nxt;
  logic [CNT_W-1:0]  count_out_r, count_out_nxt;

  logic             accept, active, is_new, bump_en;
  logic [CNT_W-1:0] cur_cnt, new_cnt;
  logic [CNT_W:0]   inc_sum;
  cell_ctl_t        ctl;
  link_t            link [LIST_DEPTH+1];

  assign in_if.ready          = !out_valid_r || out_if.ready;
  assign accept               = in_if.valid && in_if.ready;
  assign active               = stats_en_r && (in_if.event_kind != KIND_INVALID);
  assign out_if.valid         = out_valid_r;
  assign out_if.outcome       = outcome_r;
  assign out_if.counter_value = count_out_r;

  assign ctl.en     = accept && active;
  assign ctl.battle = in_if.event_kind != KIND_TRADE;
  assign ctl.id     = in_if.partner_id;

  assign link[0].trade  = in_if.partner_id;
  assign link[0].battle = in_if.partner_id;
  assign link[0].found  = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    rimtf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .link_i (link[i]),
      .link_o (link[i+1])
    );
  end

  assign is_new  = !link[LIST_DEPTH].found;
  assign bump_en = is_new && link_mode_r;

  always_comb begin
    case (in_if.event_kind)
      KIND_TRADE: cur_cnt = trade_cnt_r;
      KIND_WIN:   cur_cnt = win_cnt_r;
      KIND_LOSS:  cur_cnt = loss_cnt_r;
      default:    cur_cnt = '0;
    endcase
  end

  assign inc_sum = {1'b0, cur_cnt} + (CNT_W+1)'(1);
  assign new_cnt = !bump_en                  ? cur_cnt :
                   (inc_sum > {1'b0, limit_r}) ? limit_r : inc_sum[CNT_W-1:0];

  always_comb begin
    trade_cnt_nxt = trade_cnt_r;
    win_cnt_nxt   = win_cnt_r;
    loss_cnt_nxt  = loss_cnt_r;
    if (ctl.en) begin
      case (in_if.event_kind)
        KIND_TRADE: trade_cnt_nxt = new_cnt;
        KIND_WIN:   win_cnt_nxt   = new_cnt;
        KIND_LOSS:  loss_cnt_nxt  = new_cnt;
        default:    ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    outcome_nxt   = outcome_r;
    count_out_nxt = count_out_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (active) begin
        outcome_nxt   = is_new ? OUTC_NEW : OUTC_KNOWN;
        count_out_nxt = new_cnt;
      end else begin
        outcome_nxt   = OUTC_IGNORED;
        count_out_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_en_r  <= 1'b0;
      link_mode_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
      trade_cnt_r <= '0;
      win_cnt_r   <= '0;
      loss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      trade_cnt_r <= trade_cnt_nxt;
      win_cnt_r   <= win_cnt_nxt;
      loss_cnt_r  <= loss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_STATS_EN:  stats_en_r  <= cfg_data[0];
          CFG_LINK_MODE: link_mode_r <= cfg_data[0];
          CFG_LIMIT:     limit_r     <= cfg_data[CNT_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    outcome_r   <= outcome_nxt;
    count_out_r <= count_out_nxt;
  end

endmodule

// File: design/rimtf_chk.sv
// ---------------------------------------------------------------------------
// Recent ID move-to-front counter: port checker
// Watches the top-level ports and flags handshake or result slips.
// ---------------------------------------------------------------------------
`include "recent_id_move_to_front_counter_macros.svh"

module rimtf_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [rimtf_pkg::KIND_W-1:0]  in_event_kind,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rimtf_pkg::OUTC_W-1:0]  out_outcome,
  input logic [rimtf_pkg::CNT_W-1:0]   out_counter_value
);
  import rimtf_pkg::*;

  `RIMTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RIMTF_ASSERT_SAME(a_stall_in, out_valid && !out_ready, !in_ready)
  `RIMTF_ASSERT_NEXT(a_invalid_ignored, in_valid && in_ready && in_event_kind == KIND_INVALID, out_valid && out_outcome == OUTC_IGNORED)
  `RIMTF_ASSERT_SAME(a_ignored_zero, out_valid && out_outcome == OUTC_IGNORED, out_counter_value == '0)

endmodule

bind recent_id_move_to_front_counter rimtf_chk u_rimtf_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .in_event_kind     (in_if.event_kind),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_outcome       (out_if.outcome),
  .out_counter_value (out_if.counter_value)
);
